@@ hw/rtl/scum_pkg.sv @@
// Constants, codes and derived widths of the CPU utilisation monitor.
package scum_pkg;

  localparam int MAX_CPUS      = 64;
  localparam int NS_PER_SECOND = 1000000000;
  localparam int FRACTION_BITS = 16;

  localparam int TPS_W   = 20;   // tick rate register
  localparam int BUSY_W  = 67;   // sum of eight 64-bit deltas
  localparam int NS_W    = 30;   // bits of NS_PER_SECOND
  localparam int PCT_W   = 7;    // bits of the percent scale
  localparam int ACC_W   = 128;  // shared adder, remainder and products
  localparam int DEN_W   = BUSY_W + 1;
  localparam int Q_W     = 48;
  localparam int CORES_W = 32;
  localparam int PCTO_W  = 23;

  // numerator widths of the three divisions
  localparam int SEC_NUM_W = BUSY_W + FRACTION_BITS;
  localparam int COR_NUM_W = SEC_NUM_W + NS_W;
  localparam int PCT_NUM_W = SEC_NUM_W + PCT_W;
  localparam int CNT_W     = $clog2(COR_NUM_W);
  localparam int MUL_W     = NS_W;

  localparam logic [63:0] CPU_MASK_KEEP = {64{1'b1}} >> (64 - MAX_CPUS);
  localparam logic [63:0] GAP_LO = 64'(NS_PER_SECOND / 2);
  localparam logic [63:0] GAP_HI = 64'((3 * 64'(NS_PER_SECOND)) / 2);
  localparam logic [NS_W-1:0]   NS_BITS   = NS_W'(NS_PER_SECOND);
  localparam logic [PCT_W-1:0]  PCT_SCALE = PCT_W'(100);
  localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(100);

  // counters 0,1,2,5,6 are busy; 3 idle, 4 iowait and 7 steal are not
  localparam logic [7:0] BUSY_MASK = 8'b0110_0111;

  localparam logic REG_TPS = 1'b0;  // word index of the rate register

  typedef enum logic [2:0] {
    V_OK        = 3'd0,
    V_FIRST     = 3'd1,
    V_CPU_SET   = 3'd2,
    V_CLOCK_GAP = 3'd3,
    V_CNT_DEC   = 3'd4,
    V_NO_TICKS  = 3'd5
  } validity_t;

endpackage

@@ hw/rtl/system_cpu_utilization_monitor.sv @@
// CPU utilisation monitor: snapshot checks and Q16 busy figures on one shared adder.
//
//  channel | direction | beat contents
//  --------+-----------+-------------------------------------------------------
//  in_     | input     | read window (begin/end ns), online CPU mask, 8 counters
//  out_    | output    | validity code, busy seconds, cores, busy percent (Q16)
//  cfg     | APB slave | word 0: ticks_per_second (20 bits), always ready
//
//  A beat that passes every check runs through the checks and counter deltas
//  (PRE to ZERO), then three divider loops and three multiply loops, all on
//  the one 128-bit adder, one bit per cycle, and ends in DONE. A rejected beat
//  goes straight to DONE from the check that fails. The next beat is taken
//  only once the result has been handed to the output register.
//  Reset (synchronous, rst_n low) clears the sequencer, the output valid,
//  the previous-snapshot flag and sets the rate to 100 Hz.
//  in_ready is high only while idle; a finished result waits in the output
//  register, and the next result waits in DONE until that register is free.
module system_cpu_utilization_monitor
  import scum_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // snapshot beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_read_begin_ns,
  input  logic [63:0] in_read_end_ns,
  input  logic [63:0] in_online_cpu_mask,
  input  logic [63:0] in_user_ticks,
  input  logic [63:0] in_nice_ticks,
  input  logic [63:0] in_kernel_ticks,
  input  logic [63:0] in_idle_ticks,
  input  logic [63:0] in_iowait_ticks,
  input  logic [63:0] in_irq_ticks,
  input  logic [63:0] in_softirq_ticks,
  input  logic [63:0] in_steal_ticks,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_validity,
  output logic [47:0] out_busy_seconds_q16,
  output logic [31:0] out_cores_q16,
  output logic [22:0] out_busy_percent_q16,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_PRE     = 20'h00002,  // first sample, CPU set, rate
    S_PD      = 20'h00004,  // old window length
    S_PA      = 20'h00008,  // old midpoint
    S_CD      = 20'h00010,  // new window length
    S_CA      = 20'h00020,  // new midpoint
    S_GAP     = 20'h00040,  // midpoint gap
    S_LO      = 20'h00080,  // gap lower bound
    S_HI      = 20'h00100,  // gap upper bound
    S_CSUB    = 20'h00200,  // counter delta
    S_CTOT    = 20'h00400,  // add into total
    S_CBSY    = 20'h00800,  // add into busy
    S_ZERO    = 20'h01000,  // no-ticks check, start seconds divide
    S_DIV_SEC = 20'h02000,
    S_MUL_DEN = 20'h04000,  // rate * gap
    S_MUL_NS  = 20'h08000,  // scaled busy * ns per second
    S_DIV_COR = 20'h10000,
    S_MUL_PCT = 20'h20000,  // scaled busy * 100
    S_DIV_PCT = 20'h40000,
    S_DONE    = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  // snapshot being judged and the one before it
  logic [63:0] cur_begin_r, cur_begin_nxt, cur_end_r, cur_end_nxt;
  logic [63:0] cur_mask_r, cur_mask_nxt;
  logic [63:0] cur_cnt_r [8];
  logic [63:0] cur_cnt_nxt [8];
  logic [63:0] prev_begin_r, prev_begin_nxt, prev_end_r, prev_end_nxt;
  logic [63:0] prev_mask_r, prev_mask_nxt;
  logic [63:0] prev_cnt_r [8];
  logic [63:0] prev_cnt_nxt [8];
  logic        have_prev_r, have_prev_nxt;
  logic [TPS_W-1:0] tps_r, tps_nxt;

  // working registers
  logic [ACC_W-1:0]  acc_r, acc_nxt;     // sum, remainder or product
  logic [ACC_W-1:0]  num_r, num_nxt;     // dividend, shifted out MSB first
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic              ovf_r, ovf_nxt;     // quotient overran Q_W
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MUL_W-1:0]  mul_bits_r, mul_bits_nxt;
  logic [63:0]       tmp_r, tmp_nxt;     // half window length
  logic [63:0]       gap_r, gap_nxt;     // old midpoint, then the gap
  logic [63:0]       delta_r, delta_nxt;
  logic [BUSY_W-1:0] total_r, total_nxt, busy_r, busy_nxt;
  logic [2:0]        idx_r, idx_nxt;
  validity_t         code_r, code_nxt;
  logic [Q_W-1:0]     sec_r, sec_nxt;
  logic [CORES_W-1:0] cor_r, cor_nxt;
  logic [PCTO_W-1:0]  pct_r, pct_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  validity_t          out_code_r, out_code_nxt;
  logic [Q_W-1:0]     out_sec_r, out_sec_nxt;
  logic [CORES_W-1:0] out_cor_r, out_cor_nxt;
  logic [PCTO_W-1:0]  out_pct_r, out_pct_nxt;

  // shared adder
  logic [ACC_W-1:0] alu_a, alu_b, alu_res, mcand;
  logic [ACC_W:0]   alu_sum;
  logic             alu_sub, alu_borrow;

  logic [SEC_NUM_W-1:0] scaled;
  logic [Q_W-1:0]       q_step;
  logic                 ovf_step;
  logic [Q_W-1:0]       sec_sat;
  logic [CORES_W-1:0]   cor_sat;
  logic [PCTO_W-1:0]    pct_sat;
  logic                 in_acc, cfg_wr, is_mul_state, is_div_state;
  logic                 busy_now;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_TPS) ? 32'(tps_r) : 32'd0;

  assign out_valid            = out_valid_r;
  assign out_validity         = out_code_r;
  assign out_busy_seconds_q16 = out_sec_r;
  assign out_cores_q16        = out_cor_r;
  assign out_busy_percent_q16 = out_pct_r;

  assign scaled = {busy_r, {FRACTION_BITS{1'b0}}};
  assign is_mul_state = (state_r == S_MUL_DEN) || (state_r == S_MUL_NS) ||
                        (state_r == S_MUL_PCT);
  assign is_div_state = (state_r == S_DIV_SEC) || (state_r == S_DIV_COR) ||
                        (state_r == S_DIV_PCT);
  assign mcand = (state_r == S_MUL_DEN) ? ACC_W'(gap_r) : ACC_W'(scaled);
  assign busy_now = BUSY_MASK[idx_r];

  // operand selection for the single adder/subtractor
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    if (is_div_state) begin
      // restoring divide: shift in the next dividend bit, try subtracting
      alu_a   = {acc_r[ACC_W-2:0], num_r[ACC_W-1]};
      alu_b   = ACC_W'(den_r);
      alu_sub = 1'b1;
    end else if (is_mul_state) begin
      // shift-add multiply, multiplier bits MSB first
      alu_a = {acc_r[ACC_W-2:0], 1'b0};
      alu_b = mul_bits_r[MUL_W-1] ? mcand : '0;
    end else begin
      unique case (state_r)
        S_PD: begin
          alu_a = ACC_W'(prev_end_r); alu_b = ACC_W'(prev_begin_r); alu_sub = 1'b1;
        end
        S_PA: begin
          alu_a = ACC_W'(prev_begin_r); alu_b = ACC_W'(tmp_r);
        end
        S_CD: begin
          alu_a = ACC_W'(cur_end_r); alu_b = ACC_W'(cur_begin_r); alu_sub = 1'b1;
        end
        S_CA: begin
          alu_a = ACC_W'(cur_begin_r); alu_b = ACC_W'(tmp_r);
        end
        S_GAP: begin
          alu_a = ACC_W'(acc_r[63:0]); alu_b = ACC_W'(gap_r); alu_sub = 1'b1;
        end
        S_LO: begin
          alu_a = ACC_W'(gap_r); alu_b = ACC_W'(GAP_LO); alu_sub = 1'b1;
        end
        S_HI: begin
          alu_a = ACC_W'(GAP_HI); alu_b = ACC_W'(gap_r); alu_sub = 1'b1;
        end
        S_CSUB: begin
          alu_a = ACC_W'(cur_cnt_r[idx_r]); alu_b = ACC_W'(prev_cnt_r[idx_r]);
          alu_sub = 1'b1;
        end
        S_CTOT: begin
          alu_a = ACC_W'(total_r); alu_b = ACC_W'(delta_r);
        end
        S_CBSY: begin
          alu_a = ACC_W'(busy_r); alu_b = ACC_W'(delta_r);
        end
        default: ;
      endcase
    end
  end

  assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} +
                      (ACC_W+1)'(alu_sub);
  assign alu_res    = alu_sum[ACC_W-1:0];
  assign alu_borrow = alu_sub & ~alu_sum[ACC_W];

  // quotient after this divider step, with saturation for each output width
  assign q_step   = {q_r[Q_W-2:0], ~alu_borrow};
  assign ovf_step = ovf_r | q_r[Q_W-1];
  assign sec_sat  = ovf_step ? '1 : q_step;
  assign cor_sat  = (ovf_step || (q_step[Q_W-1:CORES_W] != '0)) ? '1
                                                                 : q_step[CORES_W-1:0];
  assign pct_sat  = (ovf_step || (q_step[Q_W-1:PCTO_W] != '0)) ? '1
                                                                : q_step[PCTO_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    cur_begin_nxt  = cur_begin_r;
    cur_end_nxt    = cur_end_r;
    cur_mask_nxt   = cur_mask_r;
    cur_cnt_nxt    = cur_cnt_r;
    prev_begin_nxt = prev_begin_r;
    prev_end_nxt   = prev_end_r;
    prev_mask_nxt  = prev_mask_r;
    prev_cnt_nxt   = prev_cnt_r;
    have_prev_nxt  = have_prev_r;
    tps_nxt        = tps_r;
    acc_nxt        = acc_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    q_nxt          = q_r;
    ovf_nxt        = ovf_r;
    cnt_nxt        = cnt_r;
    mul_bits_nxt   = mul_bits_r;
    tmp_nxt        = tmp_r;
    gap_nxt        = gap_r;
    delta_nxt      = delta_r;
    total_nxt      = total_r;
    busy_nxt       = busy_r;
    idx_nxt        = idx_r;
    code_nxt       = code_r;
    sec_nxt        = sec_r;
    cor_nxt        = cor_r;
    pct_nxt        = pct_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_code_nxt   = out_code_r;
    out_sec_nxt    = out_sec_r;
    out_cor_nxt    = out_cor_r;
    out_pct_nxt    = out_pct_r;

    if (cfg_wr && (paddr[2] == REG_TPS)) begin
      tps_nxt = pwdata[TPS_W-1:0];
    end

    // common divider / multiplier step
    if (is_div_state) begin
      acc_nxt = alu_borrow ? alu_a : alu_res;
      num_nxt = {num_r[ACC_W-2:0], 1'b0};
      q_nxt   = q_step;
      ovf_nxt = ovf_step;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (is_mul_state) begin
      acc_nxt      = alu_res;
      mul_bits_nxt = {mul_bits_r[MUL_W-2:0], 1'b0};
      cnt_nxt      = cnt_r - CNT_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cur_begin_nxt  = in_read_begin_ns;
          cur_end_nxt    = in_read_end_ns;
          cur_mask_nxt   = in_online_cpu_mask & CPU_MASK_KEEP;
          cur_cnt_nxt[0] = in_user_ticks;
          cur_cnt_nxt[1] = in_nice_ticks;
          cur_cnt_nxt[2] = in_kernel_ticks;
          cur_cnt_nxt[3] = in_idle_ticks;
          cur_cnt_nxt[4] = in_iowait_ticks;
          cur_cnt_nxt[5] = in_irq_ticks;
          cur_cnt_nxt[6] = in_softirq_ticks;
          cur_cnt_nxt[7] = in_steal_ticks;
          state_nxt      = S_PRE;
        end
      end
      S_PRE: begin
        total_nxt = '0;
        busy_nxt  = '0;
        idx_nxt   = '0;
        if (!have_prev_r) begin
          code_nxt = V_FIRST;     state_nxt = S_DONE;
        end else if (cur_mask_r != prev_mask_r) begin
          code_nxt = V_CPU_SET;   state_nxt = S_DONE;
        end else if (tps_r == '0) begin
          code_nxt = V_CLOCK_GAP; state_nxt = S_DONE;
        end else begin
          state_nxt = S_PD;
        end
      end
      S_PD: begin
        tmp_nxt = {1'b0, alu_res[63:1]};
        if (alu_borrow) begin
          code_nxt = V_CLOCK_GAP; state_nxt = S_DONE;
        end else begin
          state_nxt = S_PA;
        end
      end
      S_PA: begin
        gap_nxt   = alu_res[63:0];
        state_nxt = S_CD;
      end
      S_CD: begin
        tmp_nxt = {1'b0, alu_res[63:1]};
        if (alu_borrow) begin
          code_nxt = V_CLOCK_GAP; state_nxt = S_DONE;
        end else begin
          state_nxt = S_CA;
        end
      end
      S_CA: begin
        acc_nxt   = alu_res;
        state_nxt = S_GAP;
      end
      S_GAP: begin
        gap_nxt = alu_res[63:0];
        // new midpoint must lie strictly after the old one
        if (alu_borrow || (alu_res[63:0] == 64'd0)) begin
          code_nxt = V_CLOCK_GAP; state_nxt = S_DONE;
        end else begin
          state_nxt = S_LO;
        end
      end
      S_LO: begin
        if (alu_borrow) begin
          code_nxt = V_CLOCK_GAP; state_nxt = S_DONE;
        end else begin
          state_nxt = S_HI;
        end
      end
      S_HI: begin
        if (alu_borrow) begin
          code_nxt = V_CLOCK_GAP; state_nxt = S_DONE;
        end else begin
          state_nxt = S_CSUB;
        end
      end
      S_CSUB: begin
        delta_nxt = alu_res[63:0];
        if (alu_borrow) begin
          code_nxt = V_CNT_DEC; state_nxt = S_DONE;
        end else begin
          state_nxt = S_CTOT;
        end
      end
      S_CTOT: begin
        total_nxt = alu_res[BUSY_W-1:0];
        if (busy_now) begin
          state_nxt = S_CBSY;
        end else if (idx_r == 3'd7) begin
          state_nxt = S_ZERO;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_CSUB;
        end
      end
      S_CBSY: begin
        busy_nxt = alu_res[BUSY_W-1:0];
        if (idx_r == 3'd7) begin
          state_nxt = S_ZERO;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_CSUB;
        end
      end
      S_ZERO: begin
        if (total_r == '0) begin
          code_nxt  = V_NO_TICKS;
          state_nxt = S_DONE;
        end else begin
          // seconds = scaled / rate
          acc_nxt   = '0;
          num_nxt   = ACC_W'(scaled) << (ACC_W - SEC_NUM_W);
          den_nxt   = DEN_W'(tps_r);
          q_nxt     = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = CNT_W'(SEC_NUM_W - 1);
          state_nxt = S_DIV_SEC;
        end
      end
      S_DIV_SEC: begin
        if (cnt_r == '0) begin
          sec_nxt      = sec_sat;
          acc_nxt      = '0;
          mul_bits_nxt = MUL_W'(tps_r) << (MUL_W - TPS_W);
          cnt_nxt      = CNT_W'(TPS_W - 1);
          state_nxt    = S_MUL_DEN;
        end
      end
      S_MUL_DEN: begin
        if (cnt_r == '0) begin
          den_nxt      = alu_res[DEN_W-1:0];
          acc_nxt      = '0;
          mul_bits_nxt = NS_BITS;
          cnt_nxt      = CNT_W'(NS_W - 1);
          state_nxt    = S_MUL_NS;
        end
      end
      S_MUL_NS: begin
        if (cnt_r == '0) begin
          num_nxt   = alu_res << (ACC_W - COR_NUM_W);
          acc_nxt   = '0;
          q_nxt     = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = CNT_W'(COR_NUM_W - 1);
          state_nxt = S_DIV_COR;
        end
      end
      S_DIV_COR: begin
        if (cnt_r == '0) begin
          cor_nxt      = cor_sat;
          acc_nxt      = '0;
          mul_bits_nxt = MUL_W'(PCT_SCALE) << (MUL_W - PCT_W);
          cnt_nxt      = CNT_W'(PCT_W - 1);
          state_nxt    = S_MUL_PCT;
        end
      end
      S_MUL_PCT: begin
        if (cnt_r == '0) begin
          num_nxt   = alu_res << (ACC_W - PCT_NUM_W);
          den_nxt   = DEN_W'(total_r);
          acc_nxt   = '0;
          q_nxt     = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = CNT_W'(PCT_NUM_W - 1);
          state_nxt = S_DIV_PCT;
        end
      end
      S_DIV_PCT: begin
        if (cnt_r == '0) begin
          pct_nxt   = pct_sat;
          code_nxt  = V_OK;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output register is free; always store the snapshot
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_code_nxt   = code_r;
          out_sec_nxt    = (code_r == V_OK) ? sec_r : '0;
          out_cor_nxt    = (code_r == V_OK) ? cor_r : '0;
          out_pct_nxt    = (code_r == V_OK) ? pct_r : '0;
          have_prev_nxt  = 1'b1;
          prev_begin_nxt = cur_begin_r;
          prev_end_nxt   = cur_end_r;
          prev_mask_nxt  = cur_mask_r;
          prev_cnt_nxt   = cur_cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      tps_r       <= TPS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      tps_r       <= tps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_begin_r  <= cur_begin_nxt;
    cur_end_r    <= cur_end_nxt;
    cur_mask_r   <= cur_mask_nxt;
    cur_cnt_r    <= cur_cnt_nxt;
    prev_begin_r <= prev_begin_nxt;
    prev_end_r   <= prev_end_nxt;
    prev_mask_r  <= prev_mask_nxt;
    prev_cnt_r   <= prev_cnt_nxt;
    acc_r        <= acc_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    q_r          <= q_nxt;
    ovf_r        <= ovf_nxt;
    cnt_r        <= cnt_nxt;
    mul_bits_r   <= mul_bits_nxt;
    tmp_r        <= tmp_nxt;
    gap_r        <= gap_nxt;
    delta_r      <= delta_nxt;
    total_r      <= total_nxt;
    busy_r       <= busy_nxt;
    idx_r        <= idx_nxt;
    code_r       <= code_nxt;
    sec_r        <= sec_nxt;
    cor_r        <= cor_nxt;
    pct_r        <= pct_nxt;
    out_code_r   <= out_code_nxt;
    out_sec_r    <= out_sec_nxt;
    out_cor_r    <= out_cor_nxt;
    out_pct_r    <= out_pct_nxt;
  end

  // a rejected snapshot carries no figures
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_code_r != V_OK)) |->
      ((out_sec_r == '0) && (out_cor_r == '0) && (out_pct_r == '0)))
    else $error("rejected result with nonzero figures");

  // an accepted beat always starts at the precheck
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_PRE))
    else $error("accepted beat did not start the checks");

  // once a snapshot is stored it stays stored
  a_prev_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    have_prev_r |=> have_prev_r)
    else $error("previous-snapshot flag dropped");

  // a pending result is never overwritten by the next one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result left DONE while output was stalled");

endmodule
